/* sv/ins_pkg.sv */
package ins_pkg;

    // Control state of the sorter: collecting a set, or draining it out.
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic insert;   // place the broadcast sample into the chain
        logic shift;    // move every entry one cell toward the head
    } cell_cmd_t;

    // Status that a cell shows its neighbors.
    typedef struct packed {
        logic valid;    // cell holds an entry
        logic greater;  // entry is above the broadcast sample, or cell is empty
    } cell_link_t;

endpackage

/* sv/ins_if.sv */
interface ins_sample_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface ins_result_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         end_of_set;
    logic                         overflow;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflow, output ready);
endinterface

/* sv/insertion_sorter.sv */
// Channel   Dir  Fields                                  Accepted when
// samples   in   value, last                             valid && ready
// sorted    out  sorted_value, end_of_set, overflow      valid && ready
//
// An accepted sample goes in while the chain has room: every cell compares it
// against its entry in parallel and the chain shifts up by one above the
// insertion point. A sample marked last starts a drain of the N entries held
// (one result per cycle when sorted.ready stays high); samples are held off
// until the last result is taken. Reset empties the chain and clears the
// overflow flag. A stall on sorted freezes the chain with the head result held.
module insertion_sorter #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic                    clk,
    input logic                    rst_n,
    ins_sample_if.sink             samples,
    ins_result_if.source           sorted
);
    import ins_pkg::*;

    state_t                       state_reg;
    state_t                       state_next;
    logic                         dropped_reg;
    logic                         dropped_next;
    cell_cmd_t                    cmd;
    cell_link_t                   link  [CAPACITY];
    logic signed [DATA_WIDTH-1:0] value [CAPACITY];
    logic                         take;
    logic                         full;
    logic                         pop;
    logic                         tail;

    assign full = link[CAPACITY-1].valid;
    assign take = samples.valid && samples.ready;
    assign pop  = sorted.valid && sorted.ready;
    assign tail = !link[1].valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (take && samples.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pop && tail)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        samples.ready = 1'b0;
        sorted.valid  = 1'b0;
        cmd.insert    = 1'b0;
        cmd.shift     = 1'b0;
        dropped_next  = dropped_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                samples.ready = 1'b1;
                cmd.insert    = take && !full;
                // Drop the sample once the chain is full and flag the set.
                if (take && full)
                begin
                    dropped_next = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                sorted.valid = link[0].valid;
                cmd.shift    = pop;
                if (pop && tail)
                begin
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                dropped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    assign sorted.sorted_value = value[0];
    assign sorted.end_of_set   = tail;
    assign sorted.overflow     = dropped_reg;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_link_t                   left;
            logic signed [DATA_WIDTH-1:0] left_value;
            logic                         right_valid;
            logic signed [DATA_WIDTH-1:0] right_value;

            if (i == 0)
            begin : g_head
                // The head sees a filled, never-greater neighbor: it takes the sample.
                assign left.valid   = 1'b1;
                assign left.greater = 1'b0;
                assign left_value   = samples.value;
            end
            else
            begin : g_body
                assign left       = link[i-1];
                assign left_value = value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_valid = 1'b0;
                assign right_value = value[i];
            end
            else
            begin : g_next
                assign right_valid = link[i+1].valid;
                assign right_value = value[i+1];
            end

            ins_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .sample      (samples.value),
                .left        (left),
                .left_value  (left_value),
                .right_valid (right_valid),
                .right_value (right_value),
                .link        (link[i]),
                .value       (value[i])
            );
        end
    endgenerate

endmodule

/* sv/ins_cell.sv */
module ins_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ins_pkg::cell_cmd_t           cmd,
    input  logic signed [DATA_WIDTH-1:0] sample,
    input  ins_pkg::cell_link_t          left,
    input  logic signed [DATA_WIDTH-1:0] left_value,
    input  logic                         right_valid,
    input  logic signed [DATA_WIDTH-1:0] right_value,
    output ins_pkg::cell_link_t          link,
    output logic signed [DATA_WIDTH-1:0] value
);
    import ins_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;
    logic                         greater;

    // Empty cells count as greater so the sample lands at the first free slot.
    assign greater = !valid_reg || (value_reg > sample);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.shift)
        begin
            valid_next = right_valid;
            value_next = right_value;
        end
        else if (cmd.insert && greater)
        begin
            valid_next = valid_reg | left.valid;
            // Take the left entry if it moves up, else take the sample.
            value_next = left.greater ? left_value : sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid   = valid_reg;
    assign link.greater = greater;
    assign value        = value_reg;

endmodule
